// ===== rtl/bsw_pkg.sv =====
// ----------------------------------------------------------------------------
// bsw_pkg
// Shared constants, types and helpers for the Bezier surface warp map.
// ----------------------------------------------------------------------------
package bsw_pkg;

  localparam int GRID_ROWS     = 3;
  localparam int GRID_COLS     = 3;
  localparam int MAX_IMAGE_DIM = 4096;

  localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
  localparam int IDX_W      = $clog2(GRID_CELLS);

  // port field widths
  localparam int DIM_W     = 13;
  localparam int PIX_W     = 12;
  localparam int GRID_W    = 4;
  localparam int COORD_W   = 20;
  localparam int CFG_IDX_W = 1;

  // u/v are Q0.16 with 1.0 included, so 17 bits
  localparam int FRAC_W = 16;
  localparam int Q_W    = FRAC_W + 1;
  localparam int D_W    = $clog2(MAX_IMAGE_DIM);
  localparam int N_W    = D_W + FRAC_W;

  localparam int NU = GRID_ROWS - 1;
  localparam int NV = GRID_COLS - 1;
  localparam int NB = (NU > NV) ? NU : NV;

  localparam int DIV_LAT   = Q_W + 1;
  localparam int BASIS_LAT = NB + 2;
  localparam int FRONT_LAT = DIV_LAT + BASIS_LAT;

  localparam int W_W     = 2 * Q_W;
  localparam int PROD_W  = W_W + 1 + COORD_W;
  localparam int TREE_LV = $clog2(GRID_CELLS);
  localparam int TREE_N  = 1 << TREE_LV;
  localparam int ACC_W   = PROD_W + TREE_LV;
  localparam int ACC_LAT = TREE_LV + 3;

  typedef logic [Q_W-1:0]            q16_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam q16_t ONE_Q16 = q16_t'(1 << FRAC_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // one item in flight; pix/ld are already qualified by valid
  typedef struct packed {
    logic             pix;
    logic             ld;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
  } item_t;

  // binomial coefficient through Pascal's triangle
  function automatic int binom(int n, int k);
    int row [0:15];
    int i;
    int j;
    for (i = 0; i < 16; i++) row[i] = 0;
    row[0] = 1;
    for (i = 1; i <= n; i++) begin
      for (j = i; j >= 1; j--) row[j] = row[j] + row[j-1];
    end
    return row[k];
  endfunction

  // Q16 product, rounded half up
  function automatic q16_t mul_q16(q16_t a, q16_t b);
    logic [W_W-1:0] p;
    p = a * b + W_W'(1 << (FRAC_W - 1));
    return p[FRAC_W+Q_W-1:FRAC_W];
  endfunction

endpackage

// ===== rtl/bezier_surface_warp_map.sv =====
// ----------------------------------------------------------------------------
// bezier_surface_warp_map
// Warp coordinate map from a tensor-product Bezier surface.
// ----------------------------------------------------------------------------
// One item enters per clock unless in_stall is high. A pixel request flows
// through the one-bit-per-stage divider that forms u and v, the basis
// multiply chain, then weights, products, adder tree and rounding, which
// return its mapped coordinate. Load requests give no result and take effect
// in order with pixel requests. A stall on the output freezes the whole
// pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module bezier_surface_warp_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [bsw_pkg::GRID_W-1:0]    in_grid_row,
  input  logic [bsw_pkg::GRID_W-1:0]    in_grid_col,
  input  logic signed [bsw_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bsw_pkg::COORD_W-1:0] in_point_y,
  input  logic [bsw_pkg::PIX_W-1:0]     in_pixel_x,
  input  logic [bsw_pkg::PIX_W-1:0]     in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [bsw_pkg::COORD_W-1:0] out_mapped_x,
  output logic signed [bsw_pkg::COORD_W-1:0] out_mapped_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsw_pkg::DIM_W-1:0]     cfg_data
);
  import bsw_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             adv;
  logic             acc;
  item_t            itm_nxt;
  item_t            dl_r [0:FRONT_LAT-1];
  item_t            tail;
  q16_t             u;
  q16_t             v;
  q16_t             bu [GRID_ROWS];
  q16_t             bv [GRID_COLS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(4096);
      height_r <= DIM_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  always_comb begin
    itm_nxt.pix = acc && in_kind;
    itm_nxt.ld  = acc && !in_kind && 32'(in_grid_row) < GRID_ROWS
                  && 32'(in_grid_col) < GRID_COLS;
    itm_nxt.idx = IDX_W'(32'(in_grid_row) * GRID_COLS + 32'(in_grid_col));
    itm_nxt.x   = in_point_x;
    itm_nxt.y   = in_point_y;
  end

  // request side-band lined up with the basis output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < FRONT_LAT; s++) begin
        dl_r[s].pix <= 1'b0;
        dl_r[s].ld  <= 1'b0;
      end
    end else if (adv) begin
      dl_r[0] <= itm_nxt;
      for (int s = 1; s < FRONT_LAT; s++) dl_r[s] <= dl_r[s-1];
    end
  end

  assign tail = dl_r[FRONT_LAT-1];

  bsw_div u_div_u (
    .clk (clk),
    .en  (adv),
    .pix (in_pixel_x),
    .dim (width_r),
    .quo (u)
  );

  bsw_div u_div_v (
    .clk (clk),
    .en  (adv),
    .pix (in_pixel_y),
    .dim (height_r),
    .quo (v)
  );

  bsw_basis u_basis (
    .clk (clk),
    .en  (adv),
    .u   (u),
    .v   (v),
    .bu  (bu),
    .bv  (bv)
  );

  bsw_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .itm     (tail),
    .bu      (bu),
    .bv      (bv),
    .res_vld (out_valid),
    .res_x   (out_mapped_x),
    .res_y   (out_mapped_y)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(tail.pix && tail.ld))
    else $error("request marked both pixel and load");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tail))
    else $error("front pipeline moved while stalled");

endmodule

// ===== rtl/bsw_div.sv =====
// ----------------------------------------------------------------------------
// bsw_div
// Pipelined restoring divider: q = (pix*65536 + d/2) / d, one bit per stage.
// ----------------------------------------------------------------------------
module bsw_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bsw_pkg::PIX_W-1:0]  pix,
  input  logic [bsw_pkg::DIM_W-1:0]  dim,
  output bsw_pkg::q16_t              quo
);
  import bsw_pkg::*;

  logic [D_W-1:0] d_r   [0:Q_W];
  logic [D_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0] low_r [0:Q_W];
  logic [Q_W-1:0] quo_r [0:Q_W];

  logic [31:0]    dim_c;
  logic [D_W-1:0] d_nxt;
  logic [D_W-1:0] pc;
  logic [N_W-1:0] num;

  always_comb begin
    dim_c = 32'(dim);
    if (dim_c < 32'd2) dim_c = 32'd2;
    else if (dim_c > 32'(MAX_IMAGE_DIM)) dim_c = 32'(MAX_IMAGE_DIM);
    d_nxt = D_W'(dim_c - 32'd1);
    if (32'(pix) > 32'(d_nxt)) pc = d_nxt;
    else pc = D_W'(pix);
    num = {pc, FRAC_W'(0)} + N_W'(d_nxt >> 1);
  end

  // quotient fits Q_W bits, so the top bits seed the remainder directly
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= d_nxt;
      rem_r[0] <= D_W'(num[N_W-1:Q_W]);
      low_r[0] <= num[Q_W-1:0];
      quo_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [D_W:0]   trial;
    logic           ge;
    logic [D_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[s], low_r[s][Q_W-1]};
      ge      = trial >= {1'b0, d_r[s]};
      rem_nxt = ge ? D_W'(trial - {1'b0, d_r[s]}) : D_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s+1]   <= d_r[s];
        rem_r[s+1] <= rem_nxt;
        low_r[s+1] <= {low_r[s][Q_W-2:0], 1'b0};
        quo_r[s+1] <= {quo_r[s][Q_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[Q_W];

endmodule

// ===== rtl/bsw_basis.sv =====
// ----------------------------------------------------------------------------
// bsw_basis
// Bernstein basis values for u and v: one Q16 multiply per lane per stage,
// then the binomial scale with saturation at 1.0.
// ----------------------------------------------------------------------------
module bsw_basis (
  input  logic           clk,
  input  logic           en,
  input  bsw_pkg::q16_t  u,
  input  bsw_pkg::q16_t  v,
  output bsw_pkg::q16_t  bu [bsw_pkg::GRID_ROWS],
  output bsw_pkg::q16_t  bv [bsw_pkg::GRID_COLS]
);
  import bsw_pkg::*;

  q16_t tu_r [0:NB];
  q16_t tv_r [0:NB];
  q16_t pu_r [0:NB][GRID_ROWS];
  q16_t pv_r [0:NB][GRID_COLS];
  q16_t bu_r [GRID_ROWS];
  q16_t bv_r [GRID_COLS];

  function automatic q16_t scale_sat(q16_t p, int c);
    logic [31:0] m;
    m = 32'(p) * 32'(c);
    if (m > 32'(ONE_Q16)) return ONE_Q16;
    return q16_t'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      tu_r[0] <= u;
      tv_r[0] <= v;
      for (int k = 0; k < GRID_ROWS; k++) pu_r[0][k] <= ONE_Q16;
      for (int k = 0; k < GRID_COLS; k++) pv_r[0][k] <= ONE_Q16;
    end
  end

  // factor m of lane k: t for the first k factors, then 1-t
  for (genvar m = 0; m < NB; m++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        tu_r[m+1] <= tu_r[m];
        tv_r[m+1] <= tv_r[m];
      end
    end
    for (genvar k = 0; k < GRID_ROWS; k++) begin : g_u
      always_ff @(posedge clk) begin
        if (en) begin
          if (m >= NU) pu_r[m+1][k] <= pu_r[m][k];
          else if (m < k) pu_r[m+1][k] <= mul_q16(pu_r[m][k], tu_r[m]);
          else pu_r[m+1][k] <= mul_q16(pu_r[m][k], ONE_Q16 - tu_r[m]);
        end
      end
    end
    for (genvar k = 0; k < GRID_COLS; k++) begin : g_v
      always_ff @(posedge clk) begin
        if (en) begin
          if (m >= NV) pv_r[m+1][k] <= pv_r[m][k];
          else if (m < k) pv_r[m+1][k] <= mul_q16(pv_r[m][k], tv_r[m]);
          else pv_r[m+1][k] <= mul_q16(pv_r[m][k], ONE_Q16 - tv_r[m]);
        end
      end
    end
  end

  for (genvar k = 0; k < GRID_ROWS; k++) begin : g_bu
    always_ff @(posedge clk) begin
      if (en) bu_r[k] <= scale_sat(pu_r[NB][k], binom(NU, k));
    end
    assign bu[k] = bu_r[k];
  end

  for (genvar k = 0; k < GRID_COLS; k++) begin : g_bv
    always_ff @(posedge clk) begin
      if (en) bv_r[k] <= scale_sat(pv_r[NB][k], binom(NV, k));
    end
    assign bv[k] = bv_r[k];
  end

endmodule

// ===== rtl/bsw_accum.sv =====
// ----------------------------------------------------------------------------
// bsw_accum
// Weights, control point products, registered adder tree and final rounding with saturation.
// Control point loads are applied here so they stay in order with pixels.
// ----------------------------------------------------------------------------
module bsw_accum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  bsw_pkg::item_t  itm,
  input  bsw_pkg::q16_t   bu [bsw_pkg::GRID_ROWS],
  input  bsw_pkg::q16_t   bv [bsw_pkg::GRID_COLS],
  output logic            res_vld,
  output bsw_pkg::coord_t res_x,
  output bsw_pkg::coord_t res_y
);
  import bsw_pkg::*;

  localparam int R_W = ACC_W - 32;
  localparam logic signed [R_W-1:0] R_MAX = R_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [R_W-1:0] R_MIN = -R_W'(1 << (COORD_W - 1));

  logic                      vld_r [0:TREE_LV+2];
  item_t                     wld_r;
  logic [W_W-1:0]            w_r   [GRID_CELLS];
  coord_t                    cx_r  [GRID_CELLS];
  coord_t                    cy_r  [GRID_CELLS];
  logic signed [ACC_W-1:0]   tx_r  [0:TREE_LV][0:TREE_N-1];
  logic signed [ACC_W-1:0]   ty_r  [0:TREE_LV][0:TREE_N-1];
  coord_t                    ox_r;
  coord_t                    oy_r;

  function automatic coord_t rnd_sat(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    logic signed [R_W-1:0]   r;
    b = a + (ACC_W'(1) <<< 31);
    r = $signed(b[ACC_W-1:32]);
    if (r > R_MAX) return coord_t'(R_MAX);
    if (r < R_MIN) return coord_t'(R_MIN);
    return coord_t'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= TREE_LV + 2; s++) vld_r[s] <= 1'b0;
      wld_r.pix <= 1'b0;
      wld_r.ld  <= 1'b0;
    end else if (en) begin
      vld_r[0] <= itm.pix;
      for (int s = 1; s <= TREE_LV + 2; s++) vld_r[s] <= vld_r[s-1];
      wld_r <= itm;
    end
  end

  for (genvar i = 0; i < GRID_ROWS; i++) begin : g_wr
    for (genvar j = 0; j < GRID_COLS; j++) begin : g_wc
      always_ff @(posedge clk) begin
        if (en) w_r[i*GRID_COLS+j] <= bu[i] * bv[j];
      end
    end
  end

  // point store written in the same stage that reads it
  for (genvar c = 0; c < TREE_N; c++) begin : g_leaf
    if (c < GRID_CELLS) begin : g_cell
      always_ff @(posedge clk) begin
        if (en && wld_r.ld && wld_r.idx == IDX_W'(c)) begin
          cx_r[c] <= wld_r.x;
          cy_r[c] <= wld_r.y;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          tx_r[0][c] <= ACC_W'($signed({1'b0, w_r[c]}) * cx_r[c]);
          ty_r[0][c] <= ACC_W'($signed({1'b0, w_r[c]}) * cy_r[c]);
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          tx_r[0][c] <= '0;
          ty_r[0][c] <= '0;
        end
      end
    end
  end

  for (genvar l = 1; l <= TREE_LV; l++) begin : g_lvl
    for (genvar n = 0; n < TREE_N; n++) begin : g_node
      always_ff @(posedge clk) begin
        if (en) begin
          if (n < (TREE_N >> l)) begin
            tx_r[l][n] <= tx_r[l-1][2*n] + tx_r[l-1][2*n+1];
            ty_r[l][n] <= ty_r[l-1][2*n] + ty_r[l-1][2*n+1];
          end else begin
            tx_r[l][n] <= '0;
            ty_r[l][n] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= rnd_sat(tx_r[TREE_LV][0]);
      oy_r <= rnd_sat(ty_r[TREE_LV][0]);
    end
  end

  assign res_vld = vld_r[TREE_LV+2];
  assign res_x   = ox_r;
  assign res_y   = oy_r;

endmodule

// ===== dv/tb_bezier_surface_warp_map.sv =====
// ----------------------------------------------------------------------------
// tb_bezier_surface_warp_map
// Self-checking bench for the Bezier surface warp map. A software copy of the
// control grid and the image size predicts every pixel request, and results
// are compared in order. Stimulus is directed extremes, then random phases
// over several image sizes, with random gaps on input and output.
// ----------------------------------------------------------------------------
module tb_bezier_surface_warp_map;
  import bsw_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct {
    coord_t mx;
    coord_t my;
  } map_pt_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [GRID_W-1:0]  in_grid_row;
  logic [GRID_W-1:0]  in_grid_col;
  coord_t             in_point_x;
  coord_t             in_point_y;
  logic [PIX_W-1:0]   in_pixel_x;
  logic [PIX_W-1:0]   in_pixel_y;
  logic               out_valid;
  logic               out_stall;
  coord_t             out_mapped_x;
  coord_t             out_mapped_y;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]   cfg_data;

  bezier_surface_warp_map uut (.*);

  // software copy of the block state
  coord_t          grid_x [GRID_CELLS];
  coord_t          grid_y [GRID_CELLS];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  map_pt_t         pending_maps [$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int pix_sent;
  int load_sent;
  int maps_seen = 0;
  int cfg_writes;
  bit no_gaps;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_maps.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint clamp_dim(logic [DIM_W-1:0] d);
    if (d < 2) return 2;
    if (d > MAX_IMAGE_DIM) return MAX_IMAGE_DIM;
    return d;
  endfunction

  function automatic longint uv_of(longint pix, longint dim);
    longint d;
    d = dim - 1;
    if (pix > d) pix = d;
    return (pix * 65536 + d / 2) / d;
  endfunction

  function automatic longint bern2(int k, longint t);
    longint p;
    p = 65536;
    for (int m = 0; m < k; m++) p = (p * t + 32768) >> 16;
    for (int m = k; m < 2; m++) p = (p * (65536 - t) + 32768) >> 16;
    if (k == 1) p = p * 2;
    if (p > 65536) p = 65536;
    return p;
  endfunction

  function automatic coord_t round_q4(longint acc);
    longint r;
    r = (acc + 64'sd2147483648) >>> 32;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return coord_t'(r);
  endfunction

  function automatic map_pt_t warp_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint u, v, w, ax, ay;
    longint bu [3];
    longint bv [3];
    map_pt_t r;
    u = uv_of(px, clamp_dim(width_reg));
    v = uv_of(py, clamp_dim(height_reg));
    for (int k = 0; k < 3; k++) begin
      bu[k] = bern2(k, u);
      bv[k] = bern2(k, v);
    end
    ax = 0;
    ay = 0;
    for (int i = 0; i < GRID_ROWS; i++) begin
      for (int j = 0; j < GRID_COLS; j++) begin
        w = bu[i] * bv[j];
        ax += w * longint'(grid_x[i*GRID_COLS+j]);
        ay += w * longint'(grid_y[i*GRID_COLS+j]);
      end
    end
    r.mx = round_q4(ax);
    r.my = round_q4(ay);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    map_pt_t e;
    if (rst_n && out_valid && !out_stall) begin
      maps_seen++;
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_mapped_x, out_mapped_y);
        err_cnt++;
      end else begin
        e = pending_maps.pop_front();
        if (out_mapped_x !== e.mx) begin
          $display("%0t: mapped_x expected %0d actual %0d", $time, e.mx, out_mapped_x);
          err_cnt++;
        end
        if (out_mapped_y !== e.my) begin
          $display("%0t: mapped_y expected %0d actual %0d", $time, e.my, out_mapped_y);
          err_cnt++;
        end
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output backpressure
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = no_gaps ? 0 : rand_gap();
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = rand_gap();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_request(bit kind, logic [GRID_W-1:0] row, logic [GRID_W-1:0] col,
                              coord_t px_pt, coord_t py_pt,
                              logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_grid_row <= row;
    in_grid_col <= col;
    in_point_x  <= px_pt;
    in_point_y  <= py_pt;
    in_pixel_x  <= px;
    in_pixel_y  <= py;
    do @(posedge clk); while (in_stall);
    if (kind) begin
      pending_maps.push_back(warp_pixel(px, py));
      pix_sent++;
    end else begin
      load_sent++;
      if (row < GRID_ROWS && col < GRID_COLS) begin
        grid_x[row*GRID_COLS+col] = px_pt;
        grid_y[row*GRID_COLS+col] = py_pt;
      end
    end
    idle_gap();
  endtask

  task automatic load_point(int row, int col, coord_t x, coord_t y);
    send_request(1'b0, GRID_W'(row), GRID_W'(col), x, y,
                 PIX_W'($urandom), PIX_W'($urandom));
  endtask

  task automatic map_pixel(int px, int py);
    send_request(1'b1, GRID_W'($urandom), GRID_W'($urandom),
                 coord_t'($urandom), coord_t'($urandom), PIX_W'(px), PIX_W'(py));
  endtask

  // waits until the pipe is empty, including trailing loads
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic test_grid_extremes();
    for (int i = 0; i < GRID_CELLS; i++) begin
      case (i % 3)
        0: load_point(i / 3, i % 3, 20'sh7FFFF, -20'sh80000);
        1: load_point(i / 3, i % 3, -20'sh80000, 20'sh7FFFF);
        default: load_point(i / 3, i % 3, 20'sh00000, 20'sh00010);
      endcase
    end
    // out-of-grid loads must leave the grid alone
    load_point(3, 0, 20'sh12345, 20'sh12345);
    load_point(0, 15, 20'sh54321, 20'sh54321);
    load_point(15, 15, 20'sh0FFFF, 20'sh0FFFF);
    map_pixel(0, 0);
    map_pixel(4095, 4095);
    map_pixel(2047, 0);
    map_pixel(0, 2048);
    map_pixel(1365, 2730);
    // all points at x maximum and y minimum: saturation
    for (int i = 0; i < GRID_CELLS; i++) load_point(i / 3, i % 3, 20'sh7FFFF, -20'sh80000);
    map_pixel(2047, 2047);
    map_pixel(100, 3000);
  endtask

  task automatic test_size_extremes();
    set_size(0, 1);          // below range, counts as 2
    map_pixel(0, 0);
    map_pixel(1, 1);
    map_pixel(4095, 0);
    set_size(8191, 4097);    // above range, counts as max
    map_pixel(4095, 4095);
    map_pixel(2048, 1);
    set_size(2, 3);
    map_pixel(1, 2);
    map_pixel(0, 1);
    map_pixel(4000, 4000);   // beyond edge
  endtask

  task automatic random_phase(int n_items);
    int px, py, w, h;
    w = int'(clamp_dim(width_reg));
    h = int'(clamp_dim(height_reg));
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        load_point($urandom_range(0, 15) < 12 ? $urandom_range(0, 2) : $urandom_range(0, 15),
                   $urandom_range(0, 15) < 12 ? $urandom_range(0, 2) : $urandom_range(0, 15),
                   coord_t'($urandom), coord_t'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0: begin px = $urandom; py = $urandom; end
          1: begin px = w - 1; py = h - 1 - $urandom_range(0, 1); end
          default: begin px = $urandom_range(0, w - 1); py = $urandom_range(0, h - 1); end
        endcase
        map_pixel(px[PIX_W-1:0], py[PIX_W-1:0]);
      end
    end
  endtask

  task automatic test_random_sizes();
    for (int i = 0; i < GRID_CELLS; i++) begin
      load_point(i / 3, i % 3, coord_t'($urandom), coord_t'($urandom));
    end
    set_size(4096, 4096);
    random_phase(300);
    set_size(640, 480);
    random_phase(300);
    no_gaps = 1'b1;
    random_phase(200);
    no_gaps = 1'b0;
    set_size(2, 2);
    random_phase(200);
    set_size(8191, 17);
    random_phase(250);
    set_size(DIM_W'($urandom_range(0, 8191)), DIM_W'($urandom_range(0, 8191)));
    random_phase(300);
    set_size(DIM_W'($urandom_range(2, 300)), DIM_W'($urandom_range(2, 300)));
    random_phase(300);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_grid_row = '0;
    in_grid_col = '0;
    in_point_x = '0;
    in_point_y = '0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    width_reg = 13'd4096;
    height_reg = 13'd4096;
    for (int i = 0; i < GRID_CELLS; i++) begin
      grid_x[i] = '0;
      grid_y[i] = '0;
    end
    pix_sent = 0;
    load_sent = 0;
    cfg_writes = 0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_grid_extremes();
    test_size_extremes();
    test_random_sizes();

    drain();
    $display("Covered %0d pixel and %0d load requests, %0d register writes, %0d results.",
             pix_sent, load_sent, cfg_writes, maps_seen);
    $display("Sizes ran from clamped low to clamped high, with input gaps and output stalls.");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bsw_pkg.sv
rtl/bsw_div.sv
rtl/bsw_basis.sv
rtl/bsw_accum.sv
rtl/bezier_surface_warp_map.sv
dv/tb_bezier_surface_warp_map.sv
